[src/mmvp_pkg.sv]
// ----------------------------------------------------------------------------
// mmvp_pkg
// Shared types and constants of the macroblock motion vector predictor.
// ----------------------------------------------------------------------------
package mmvp_pkg;

  localparam int unsigned MvW    = 14;
  localparam int unsigned SliceW = 8;
  localparam int unsigned CfgW   = 8;

  // One stored macroblock, packed MSB first: slice, intra, mv_y, mv_x.
  typedef struct packed {
    logic [SliceW-1:0] slice_id;
    logic              is_intra;
    logic [MvW-1:0]    mv_y;
    logic [MvW-1:0]    mv_x;
  } mb_entry_t;

  localparam int unsigned EntryW = $bits(mb_entry_t);

  typedef logic signed [MvW-1:0] mv_t;

endpackage

[src/macroblock_motion_vector_predictor.sv]
// ----------------------------------------------------------------------------
// macroblock_motion_vector_predictor
// Median motion vector prediction for 16x16 macroblocks in raster order.
// ----------------------------------------------------------------------------
// Usage:
// Macroblocks enter on the input channel (in_valid_i / in_stall_o), one word
// each, carrying a start-of-picture mark, slice id, intra flag and the
// macroblock's own vector. For every word one prediction word leaves on the
// output channel (out_valid_o / out_stall_i), in the same order.
// The picture width in macroblocks is set through cfg_we_i / cfg_wdata_i; a
// value of zero acts as one and a value above MAX_MB_COLUMNS acts as
// MAX_MB_COLUMNS. Write it only while the block is idle.
// An accepted word waits in the compute stage until the output register is
// free, then moves there and raises out_valid_o. A new word can be accepted
// every cycle unless the output stalls: the row store is kept in two identical
// copies so that the above and above-right entries are read in the same cycle,
// and a write that lands in the same cycle as a read of that entry is forwarded.
// Reset empties the pipeline, clears the left and above-left registers,
// puts the position at column zero of the top row and sets the width to one.
// The row store itself is not cleared; the top row never reads it.
// When the receiver stalls, the result waits in the output register, the
// word behind it waits in the compute stage, and in_stall_o goes high.
// ----------------------------------------------------------------------------
module macroblock_motion_vector_predictor
  import mmvp_pkg::*;
#(
  parameter int unsigned MAX_MB_COLUMNS = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgW-1:0]       cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  start_of_picture_i,
  input  logic [SliceW-1:0]     slice_id_i,
  input  logic                  is_intra_i,
  input  logic signed [MvW-1:0] mv_x_i,
  input  logic signed [MvW-1:0] mv_y_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [MvW-1:0] pred_mv_x_o,
  output logic signed [MvW-1:0] pred_mv_y_o
);

  // Column index width and the width of a count that can hold the column total.
  localparam int unsigned ColW  = (MAX_MB_COLUMNS > 1) ? $clog2(MAX_MB_COLUMNS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_MB_COLUMNS + 1);
  localparam int unsigned CmpW  = (CntW > CfgW) ? CntW : CfgW;

  // --------------------------------------------------------------------------
  // Configuration and effective width
  // --------------------------------------------------------------------------
  logic [CfgW-1:0] cfg_width_q;
  logic [CmpW-1:0] cfg_ext;
  logic [CntW-1:0] width_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q <= CfgW'(1);
    end else if (cfg_we_i) begin
      cfg_width_q <= cfg_wdata_i;
    end
  end

  assign cfg_ext = CmpW'(cfg_width_q);

  always_comb begin
    if (cfg_width_q == '0) begin
      width_eff = CntW'(1);
    end else if (cfg_ext > CmpW'(MAX_MB_COLUMNS)) begin
      width_eff = CntW'(MAX_MB_COLUMNS);
    end else begin
      width_eff = CntW'(cfg_ext);
    end
  end

  // --------------------------------------------------------------------------
  // Handshake between stages
  // --------------------------------------------------------------------------
  logic e_valid_q;
  logic out_valid_q;
  logic e_adv;
  logic in_accept;

  // The compute stage hands its word to the output register when that
  // register is empty or being emptied in this cycle.
  assign e_adv      = !out_valid_q || !out_stall_i;
  assign in_stall_o = e_valid_q && !e_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // Position tracking at acceptance
  // --------------------------------------------------------------------------
  logic [ColW-1:0] col_q, col_d;
  logic            first_row_q, first_row_d;
  logic [ColW-1:0] col_cur;
  logic            first_cur;
  logic [CntW-1:0] col_p1;
  logic            ar_ok;

  always_comb begin
    col_cur   = col_q;
    first_cur = first_row_q;
    if (start_of_picture_i) begin
      col_cur   = '0;
      first_cur = 1'b1;
    end
    if (CntW'(col_cur) >= width_eff) begin
      col_cur = '0;
    end
    col_p1 = CntW'(col_cur) + CntW'(1);
    ar_ok  = col_p1 < width_eff;
    if (ar_ok) begin
      col_d       = ColW'(col_p1);
      first_row_d = first_cur;
    end else begin
      col_d       = '0;
      first_row_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      first_row_q <= 1'b1;
    end else if (in_accept) begin
      col_q       <= col_d;
      first_row_q <= first_row_d;
    end
  end

  // --------------------------------------------------------------------------
  // Row store: two copies, one read at the column, one at the column after it
  // --------------------------------------------------------------------------
  mb_entry_t       e_cur_q;
  logic [ColW-1:0] e_col_q;
  logic            e_first_q;
  logic            e_ar_ok_q;
  logic            wr_en;
  logic [ColW-1:0] rd_addr_b;
  logic [ColW-1:0] rd_addr_c;
  mb_entry_t       ram_b_rdata;
  mb_entry_t       ram_c_rdata;
  mb_entry_t       in_entry;

  assign wr_en     = e_valid_q && e_adv;
  assign rd_addr_b = col_cur;
  assign rd_addr_c = ColW'(col_p1);

  assign in_entry.slice_id = slice_id_i;
  assign in_entry.is_intra = is_intra_i;
  assign in_entry.mv_y     = mv_y_i;
  assign in_entry.mv_x     = mv_x_i;

  mmvp_ram #(
    .Width (EntryW),
    .Depth (MAX_MB_COLUMNS)
  ) u_ram_above (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (e_col_q),
    .wdata_i (e_cur_q),
    .re_i    (in_accept),
    .raddr_i (rd_addr_b),
    .rdata_o (ram_b_rdata)
  );

  mmvp_ram #(
    .Width (EntryW),
    .Depth (MAX_MB_COLUMNS)
  ) u_ram_above_right (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (e_col_q),
    .wdata_i (e_cur_q),
    .re_i    (in_accept),
    .raddr_i (rd_addr_c),
    .rdata_o (ram_c_rdata)
  );

  // A write in the same cycle as the read of that entry does not show in
  // the read data, so the written word is captured beside it.
  logic      fwd_b_q;
  logic      fwd_c_q;
  mb_entry_t fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
      fwd_b_q   <= 1'b0;
      fwd_c_q   <= 1'b0;
    end else begin
      if (in_accept) begin
        e_valid_q <= 1'b1;
        fwd_b_q   <= wr_en && (e_col_q == rd_addr_b);
        fwd_c_q   <= wr_en && (e_col_q == rd_addr_c);
      end else if (e_adv) begin
        e_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      e_cur_q    <= in_entry;
      e_col_q    <= col_cur;
      e_first_q  <= first_cur;
      e_ar_ok_q  <= ar_ok;
      fwd_data_q <= e_cur_q;
    end
  end

  // --------------------------------------------------------------------------
  // Compute stage: neighbor availability and median
  // --------------------------------------------------------------------------
  mb_entry_t left_q;
  mb_entry_t above_left_q;
  mb_entry_t above_e;
  mb_entry_t above_right_e;
  logic      has_a, has_b, has_c, has_d;
  logic      col_gt0;
  mv_t       ax, ay, bx, by, cx, cy;
  mv_t       med_x, med_y;

  function automatic mv_t median3(input mv_t a, input mv_t b, input mv_t c);
    logic ab, bc, ac;
    mv_t  res;
    ab = a < b;
    bc = b < c;
    ac = a < c;
    if (ab == bc) begin
      res = b;
    end else if (ab == ac) begin
      res = c;
    end else begin
      res = a;
    end
    return res;
  endfunction

  assign above_e       = fwd_b_q ? fwd_data_q : ram_b_rdata;
  assign above_right_e = fwd_c_q ? fwd_data_q : ram_c_rdata;
  assign col_gt0       = (e_col_q != '0);

  always_comb begin
    has_a = col_gt0 && (left_q.slice_id == e_cur_q.slice_id);
    has_b = !e_first_q && (above_e.slice_id == e_cur_q.slice_id);
    has_c = !e_first_q && e_ar_ok_q && (above_right_e.slice_id == e_cur_q.slice_id);
    has_d = !e_first_q && col_gt0 && (above_left_q.slice_id == e_cur_q.slice_id);

    ax = '0;
    ay = '0;
    bx = '0;
    by = '0;
    cx = '0;
    cy = '0;
    if (has_a && !left_q.is_intra) begin
      ax = mv_t'(left_q.mv_x);
      ay = mv_t'(left_q.mv_y);
    end
    if (has_b && !above_e.is_intra) begin
      bx = mv_t'(above_e.mv_x);
      by = mv_t'(above_e.mv_y);
    end
    if (has_c) begin
      if (!above_right_e.is_intra) begin
        cx = mv_t'(above_right_e.mv_x);
        cy = mv_t'(above_right_e.mv_y);
      end
    end else if (has_d && !above_left_q.is_intra) begin
      cx = mv_t'(above_left_q.mv_x);
      cy = mv_t'(above_left_q.mv_y);
    end
    // With neither B nor C present, the prediction falls back to A.
    if (!has_b && !has_c) begin
      bx = ax;
      by = ay;
      cx = ax;
      cy = ay;
    end
    med_x = median3(ax, bx, cx);
    med_y = median3(ay, by, cy);
  end

  // Left and above-left follow the word leaving the compute stage; on the
  // top row the above entry does not exist and counts as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q       <= '0;
      above_left_q <= '0;
    end else if (wr_en) begin
      left_q       <= e_cur_q;
      above_left_q <= e_first_q ? mb_entry_t'('0) : above_e;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  mv_t pred_x_q;
  mv_t pred_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (e_adv) begin
      out_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pred_x_q <= med_x;
      pred_y_q <= med_y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pred_mv_x_o = pred_x_q;
  assign pred_mv_y_o = pred_y_q;

endmodule

[src/mmvp_ram.sv]
// ----------------------------------------------------------------------------
// mmvp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mmvp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[tb/mmvp_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mmvp_checker
// Watches the channels of the motion vector predictor, keeps its own model of
// the neighbour state and compares every prediction word with the expectation.
// ----------------------------------------------------------------------------
module mmvp_checker
  import mmvp_pkg::*;
#(
  parameter int unsigned MAX_MB_COLUMNS = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgW-1:0]       cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  start_of_picture_i,
  input  logic [SliceW-1:0]     slice_id_i,
  input  logic                  is_intra_i,
  input  logic signed [MvW-1:0] mv_x_i,
  input  logic signed [MvW-1:0] mv_y_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic signed [MvW-1:0] pred_mv_x_i,
  input  logic signed [MvW-1:0] pred_mv_y_i,
  output int unsigned           mismatches_o,
  output int unsigned           pending_o
);

  typedef struct {
    mv_t x;
    mv_t y;
  } pred_mv_t;

  pred_mv_t        expected_pred_q[$];
  mb_entry_t       row_mem[MAX_MB_COLUMNS];
  mb_entry_t       left_mb;
  mb_entry_t       above_left_mb;
  int unsigned     col_pos;
  bit              first_row;
  logic [CfgW-1:0] width_reg;

  // Vector component of a neighbour; an intra neighbour counts as zero.
  function automatic int mv_part(mb_entry_t e, bit vertical);
    mv_t v;
    v = vertical ? e.mv_y : e.mv_x;
    return e.is_intra ? 0 : int'(v);
  endfunction

  function automatic int median_of3(int a, int b, int c);
    int lo;
    int hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (c < lo) ? lo : ((c > hi) ? hi : c);
  endfunction

  // Works out the prediction for one macroblock, records it as the new left and
  // row entry, takes its above as above-left, advancing the raster position.
  function automatic pred_mv_t predict_median_mv(mb_entry_t cur, bit sop);
    pred_mv_t    res;
    int unsigned w;
    int unsigned col;
    mb_entry_t   above;
    mb_entry_t   above_right;
    bit          right_in;
    bit          has_a;
    bit          has_b;
    bit          has_c;
    bit          has_d;
    int          ax;
    int          ay;
    int          bx;
    int          by;
    int          cx;
    int          cy;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_MB_COLUMNS) ? MAX_MB_COLUMNS : width_reg);
    if (sop) begin
      col_pos   = 0;
      first_row = 1'b1;
    end
    if (col_pos >= w) col_pos = 0;
    col         = col_pos;
    right_in    = (col + 1 < w);
    above       = '0;
    above_right = '0;
    if (!first_row) begin
      above = row_mem[col];
      if (right_in) above_right = row_mem[col + 1];
    end
    has_a = (col > 0) && (left_mb.slice_id == cur.slice_id);
    has_b = !first_row && (above.slice_id == cur.slice_id);
    has_c = !first_row && right_in && (above_right.slice_id == cur.slice_id);
    has_d = !first_row && (col > 0) && (above_left_mb.slice_id == cur.slice_id);
    ax = has_a ? mv_part(left_mb, 1'b0) : 0;
    ay = has_a ? mv_part(left_mb, 1'b1) : 0;
    bx = has_b ? mv_part(above, 1'b0) : 0;
    by = has_b ? mv_part(above, 1'b1) : 0;
    cx = 0;
    cy = 0;
    if (has_c) begin
      cx = mv_part(above_right, 1'b0);
      cy = mv_part(above_right, 1'b1);
    end else if (has_d) begin
      cx = mv_part(above_left_mb, 1'b0);
      cy = mv_part(above_left_mb, 1'b1);
    end
    if (!has_b && !has_c) begin
      bx = ax;
      by = ay;
      cx = ax;
      cy = ay;
    end
    res.x = mv_t'(median_of3(ax, bx, cx));
    res.y = mv_t'(median_of3(ay, by, cy));
    above_left_mb = above;
    row_mem[col]  = cur;
    left_mb       = cur;
    if (col + 1 >= w) begin
      col_pos   = 0;
      first_row = 1'b0;
    end else begin
      col_pos = col + 1;
    end
    return res;
  endfunction

  function automatic void note_mismatch(string what, int want_x, int want_y);
    mismatches_o++;
    if (mismatches_o <= 10) begin
      $display("%0t: %s: expected (%0d, %0d), got (%0d, %0d)", $time, what,
               want_x, want_y, pred_mv_x_i, pred_mv_y_i);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pred_mv_t  want;
    mb_entry_t cur;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_MB_COLUMNS; i++) row_mem[i] = '0;
      left_mb       = '0;
      above_left_mb = '0;
      col_pos       = 0;
      first_row     = 1'b1;
      width_reg     = 1;
      expected_pred_q.delete();
      mismatches_o  = 0;
      pending_o     = 0;
    end else begin
      // A result never leaves at the edge that accepts its input, so pop before push.
      if (out_valid_i && !out_stall_i) begin
        if (expected_pred_q.size() == 0) begin
          note_mismatch("unexpected prediction word", 0, 0);
        end else begin
          want = expected_pred_q.pop_front();
          if (pred_mv_x_i !== want.x || pred_mv_y_i !== want.y) begin
            note_mismatch("prediction mismatch", want.x, want.y);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        cur.slice_id = slice_id_i;
        cur.is_intra = is_intra_i;
        cur.mv_y     = mv_y_i;
        cur.mv_x     = mv_x_i;
        expected_pred_q.push_back(predict_median_mv(cur, start_of_picture_i));
      end
      if (cfg_we_i) width_reg = cfg_wdata_i;
      pending_o = expected_pred_q.size();
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the macroblock motion vector predictor. Drives macroblock
// words and picture widths, varies idling on both channels, and leaves all
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb
  import mmvp_pkg::*;
();

  localparam int unsigned MaxCols     = 128;
  localparam int unsigned ResetCycles = 11;
  // Cycles without any accepted word before the run is declared hung. The
  // longest honest quiet stretch is the receiver hold-off below plus a drain.
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned HoldLen     = 300;
  // Cycles waited after the last prediction is back, to let the pipeline settle.
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned NumPhases   = 12;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CfgW-1:0]       cfg_wdata   = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic                  sop         = 1'b0;
  logic [SliceW-1:0]     slice_id    = '0;
  logic                  is_intra    = 1'b0;
  logic signed [MvW-1:0] mv_x        = '0;
  logic signed [MvW-1:0] mv_y        = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic signed [MvW-1:0] pred_mv_x;
  logic signed [MvW-1:0] pred_mv_y;

  int unsigned mismatches;
  int unsigned pending;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  // Shadow of the raster position, kept by the stimulus only so that it never
  // sends a word whose above or above-right row entry has not been written
  // since reset. Such a word is forced to start a new picture instead.
  bit                col_written[MaxCols];
  int unsigned       trk_col   = 0;
  int unsigned       trk_width = 1;
  bit                trk_first = 1'b1;
  logic [SliceW-1:0] cur_slice = '0;

  always #2 clk = ~clk;

  macroblock_motion_vector_predictor #(
    .MAX_MB_COLUMNS(MaxCols)
  ) u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .start_of_picture_i(sop),
    .slice_id_i        (slice_id),
    .is_intra_i        (is_intra),
    .mv_x_i            (mv_x),
    .mv_y_i            (mv_y),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .pred_mv_x_o       (pred_mv_x),
    .pred_mv_y_o       (pred_mv_y)
  );

  mmvp_checker #(
    .MAX_MB_COLUMNS(MaxCols)
  ) u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .start_of_picture_i(sop),
    .slice_id_i        (slice_id),
    .is_intra_i        (is_intra),
    .mv_x_i            (mv_x),
    .mv_y_i            (mv_y),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .pred_mv_x_i       (pred_mv_x),
    .pred_mv_y_i       (pred_mv_y),
    .mismatches_o      (mismatches),
    .pending_o         (pending)
  );

  // Receiver. A hold-off request makes it stall for a long stretch counted
  // here; otherwise it stalls at random with the current percentage.
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HoldLen;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: any accepted word on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Idling percentages change just after a rising edge so that the drivers,
  // which act on falling edges, never race with the change.
  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Sends one macroblock word and returns at the edge where it is accepted.
  // Valid stays high afterwards; the next call or a drain decides its fate.
  task automatic send_mb(input bit sop_in, input logic [SliceW-1:0] sl,
                         input bit intra, input mv_t x, input mv_t y);
    bit          sop_bit;
    int unsigned c;
    sop_bit = sop_in;
    c = (trk_col >= trk_width) ? 0 : trk_col;
    if (!sop_bit && !trk_first &&
        (!col_written[c] || (c + 1 < trk_width && !col_written[c + 1]))) begin
      sop_bit = 1'b1;
    end
    if (sop_bit) begin
      c         = 0;
      trk_first = 1'b1;
    end
    col_written[c] = 1'b1;
    if (c + 1 >= trk_width) begin
      trk_col   = 0;
      trk_first = 1'b0;
    end else begin
      trk_col = c + 1;
    end

    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sop      <= sop_bit;
    slice_id <= sl;
    is_intra <= intra;
    mv_x     <= x;
    mv_y     <= y;
    do @(posedge clk); while (in_stall);
  endtask

  // Withdraws the sender and waits until every prediction has come back,
  // then lets the pipeline settle.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // Width changes only while the block is idle. Out-of-range values are
  // written on purpose; the shadow position uses the clamped width.
  task automatic write_width(input logic [CfgW-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    trk_width = (value == 0) ? 1 : ((value > MaxCols) ? MaxCols : value);
  endtask

  // Mostly small vectors so that medians often tie or sit close together,
  // some across the whole range and some at the very ends.
  function automatic mv_t rand_mv();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return mv_t'(int'($urandom_range(128)) - 64);
    if (r < 90) return mv_t'($urandom);
    case ($urandom_range(3))
      0:       return mv_t'(-8192);
      1:       return mv_t'(8191);
      2:       return mv_t'(-1);
      default: return mv_t'(0);
    endcase
  endfunction

  // Random macroblock within a picture: slices run in long stretches, a few
  // stray slice ids and stray picture starts break the pattern.
  task automatic send_random_mb(input bit force_sop);
    int unsigned       r;
    logic [SliceW-1:0] sl;
    bit                sop_bit;
    sop_bit = force_sop || ($urandom_range(99) < 2);
    r = $urandom_range(99);
    if (r < 4) cur_slice = SliceW'($urandom);
    sl = cur_slice;
    if (r >= 96) sl = SliceW'($urandom);
    send_mb(sop_bit, sl, $urandom_range(99) < 15, rand_mv(), rand_mv());
  endtask

  initial begin
    logic [CfgW-1:0] phase_width[NumPhases];
    int unsigned     w_eff;
    int unsigned     n_items;

    phase_width = '{2, 0, 128, 1, 6, 255, 3, 40, 5, 17, 1, 4};

    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;

    set_idling(18, 84);

    // Width one straight out of reset, first word without a picture start.
    // Every macroblock sits in column zero, so only the above neighbour helps.
    send_mb(1'b0, 8'd5, 1'b0, mv_t'(8191), mv_t'(-8192));
    send_mb(1'b0, 8'd5, 1'b1, mv_t'(-8192), mv_t'(8191));
    send_mb(1'b0, 8'd5, 1'b0, mv_t'(100), mv_t'(-100));
    send_mb(1'b0, 8'd6, 1'b0, mv_t'(-1), mv_t'(1));

    // Four columns: a full top row, then a row that meets an intra above-right,
    // an above-right in another slice (falls back to above-left) and the
    // right edge, then a macroblock in a slice that has no neighbours at all.
    write_width(4);
    send_mb(1'b1, 8'd7, 1'b0, mv_t'(10), mv_t'(20));
    send_mb(1'b0, 8'd7, 1'b0, mv_t'(-30), mv_t'(40));
    send_mb(1'b0, 8'd7, 1'b1, mv_t'(50), mv_t'(60));
    send_mb(1'b0, 8'd8, 1'b0, mv_t'(70), mv_t'(-80));
    send_mb(1'b0, 8'd7, 1'b0, mv_t'(1), mv_t'(2));
    send_mb(1'b0, 8'd7, 1'b0, mv_t'(3), mv_t'(4));
    send_mb(1'b0, 8'd7, 1'b0, mv_t'(5), mv_t'(6));
    send_mb(1'b0, 8'd8, 1'b0, mv_t'(7), mv_t'(8));
    send_mb(1'b0, 8'd9, 1'b0, mv_t'(11), mv_t'(12));

    // Width shrinks mid-picture: the column wraps at once without a new row.
    write_width(1);
    send_mb(1'b0, 8'd9, 1'b0, mv_t'(-5), mv_t'(5));
    send_mb(1'b0, 8'd9, 1'b0, mv_t'(6), mv_t'(-6));

    // Width grows mid-picture, only as far as row entries already written.
    write_width(3);
    send_mb(1'b0, 8'd9, 1'b0, mv_t'(13), mv_t'(14));
    send_mb(1'b0, 8'd9, 1'b0, mv_t'(15), mv_t'(16));
    send_mb(1'b0, 8'd9, 1'b0, mv_t'(17), mv_t'(18));

    // Widest picture with vectors at the ends of the range.
    write_width(128);
    send_mb(1'b1, 8'd0, 1'b0, mv_t'(8191), mv_t'(8191));
    send_mb(1'b0, 8'd0, 1'b0, mv_t'(-8192), mv_t'(-8192));
    send_mb(1'b0, 8'd0, 1'b0, mv_t'(8191), mv_t'(-8192));
    send_mb(1'b0, 8'd255, 1'b1, mv_t'(-8192), mv_t'(8191));

    // Random pictures. The first third has a slow receiver, the second a slow
    // sender, the last neither. Wide pictures run for two rows and a bit so
    // that the row store is read back.
    for (int p = 0; p < NumPhases; p++) begin
      // The width write drains the block first, so the idling change below
      // never finds a word still offered on the input.
      write_width(phase_width[p]);
      if (p == 4) set_idling(84, 18);
      if (p == 8) set_idling(0, 0);
      w_eff   = (phase_width[p] == 0) ? 1 :
                ((phase_width[p] > MaxCols) ? MaxCols : phase_width[p]);
      n_items = (w_eff > 20) ? 2 * w_eff + 10 : 40;
      for (int i = 0; i < n_items; i++) begin
        // The sender stops once mid-picture until every prediction is back.
        if (p == 1 && i == 20) wait_drained();
        // The receiver holds off for a long stretch while the sender keeps
        // offering words, so the block fills up and stalls its input.
        if (p == 9 && i == 0) begin
          @(posedge clk);
          hold_requests++;
        end
        send_random_mb(i == 0);
      end
    end

    wait_drained();
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
